>>> design/lpg_pkg.sv
// ---------------------------------------------------------------------------
// Line pixel generator package
// Shared constants, beat types and field codes for the line pixel generator.
// ---------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   // Coordinate width of every endpoint and pixel field.
   localparam int COORD_BITS = 10;
   // Signed error term width: one bit for sign and one for headroom.
   localparam int ERR_BITS   = COORD_BITS + 2;
   // Width of the screen sizes written through the configuration port.
   localparam int CSR_BITS   = 11;
   localparam int CSR_INDEX_BITS = 1;
   // Largest coordinate value.
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // Reset sizes of the screen.
   localparam logic [CSR_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [CSR_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd240;

   // Codes of the kind field.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Input beat.
   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [15:0]           line_color;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [15:0]           pixel_color;
      logic                  last_pixel;
   } rsp_type;

   // What the stepping core hands back for one item.
   typedef struct packed {
      logic    emit;
      rsp_type pixel;
   } step_type;

endpackage

`default_nettype wire

>>> design/lpg_core.sv
// ---------------------------------------------------------------------------
// Line pixel generator stepping core
// Holds the line state and performs a line start, or one Bresenham step while
// a line is in progress, for each item that fires.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire lpg_pkg::req_type item,
   output lpg_pkg::step_type    step
);
   import lpg_pkg::*;

   // Line state.
   logic                  active_ff,     active_in;
   logic [COORD_BITS-1:0] cur_x_ff,      cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff,      cur_y_in;
   logic [COORD_BITS-1:0] target_x_ff,   target_x_in;
   logic [COORD_BITS-1:0] target_y_ff,   target_y_in;
   logic [COORD_BITS-1:0] delta_x_ff,    delta_x_in;
   logic [COORD_BITS-1:0] delta_y_ff,    delta_y_in;
   logic                  step_x_neg_ff, step_x_neg_in;
   logic                  step_y_neg_ff, step_y_neg_in;
   logic signed [ERR_BITS-1:0] error_ff, error_in;
   logic [15:0]           color_ff,      color_in;

   // Start path signals.
   logic                  swap;
   logic [COORD_BITS-1:0] sx, sy, ex, ey;
   logic                  sx_neg, sy_neg;
   logic [COORD_BITS-1:0] sdx, sdy;
   logic signed [ERR_BITS-1:0] err_init;

   // Step path signals.
   logic signed [ERR_BITS-1:0] dx_s, dy_s;
   logic                  move_x, move_y;
   logic signed [ERR_BITS-1:0] err_step;
   logic [COORD_BITS-1:0] nx, ny;

   logic is_start;
   logic last;

   assign is_start = (item.kind == KIND_START);

   // Line start: order axis-aligned lines, take signs, extents and the
   // initial error.
   always_comb begin
      swap = ((item.start_x == item.end_x) || (item.start_y == item.end_y)) &&
             ((item.start_x > item.end_x) || (item.start_y > item.end_y));
      sx = swap ? item.end_x   : item.start_x;
      sy = swap ? item.end_y   : item.start_y;
      ex = swap ? item.start_x : item.end_x;
      ey = swap ? item.start_y : item.end_y;
      sx_neg = (ex < sx);
      sy_neg = (ey < sy);
      sdx = sx_neg ? (sx - ex) : (ex - sx);
      sdy = sy_neg ? (sy - ey) : (ey - sy);
      if (sdx > sdy) begin
         err_init = $signed({2'b00, sdx >> 1});
      end else begin
         err_init = -$signed({2'b00, sdy >> 1});
      end
   end

   // One Bresenham step from the held state.
   always_comb begin
      dx_s   = $signed({2'b00, delta_x_ff});
      dy_s   = $signed({2'b00, delta_y_ff});
      move_x = (error_ff > -dx_s);
      move_y = (error_ff < dy_s);
      err_step = error_ff - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
      nx = cur_x_ff;
      ny = cur_y_ff;
      if (move_x) begin
         nx = step_x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
      end
      if (move_y) begin
         ny = step_y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
      end
   end

   // Next state and the emitted pixel.
   always_comb begin
      active_in     = active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      step.emit     = 1'b0;
      if (fire && is_start) begin
         cur_x_in      = sx;
         cur_y_in      = sy;
         target_x_in   = ex;
         target_y_in   = ey;
         delta_x_in    = sdx;
         delta_y_in    = sdy;
         step_x_neg_in = sx_neg;
         step_y_neg_in = sy_neg;
         error_in      = err_init;
         color_in      = item.line_color;
         step.emit     = 1'b1;
      end else if (fire && active_ff) begin
         cur_x_in  = nx;
         cur_y_in  = ny;
         error_in  = err_step;
         step.emit = 1'b1;
      end
      last = (cur_x_in == target_x_in) && (cur_y_in == target_y_in);
      if (step.emit) begin
         active_in = !last;
      end
      step.pixel.pixel_x     = cur_x_in;
      step.pixel.pixel_y     = cur_y_in;
      step.pixel.pixel_color = color_in;
      step.pixel.last_pixel  = last;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Line payload state.
   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      target_x_ff   <= target_x_in;
      target_y_ff   <= target_y_in;
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      error_ff      <= error_in;
      color_ff      <= color_in;
   end

   // A start always produces its first pixel.
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      (fire && item.kind == KIND_START) |-> step.emit)
      else $error("line start produced no pixel");

   // A step with no line in progress produces nothing.
   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && item.kind == KIND_STEP && !active_ff) |-> !step.emit)
      else $error("pixel emitted with no active line");

   // After the final endpoint the line is closed.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (step.emit && step.pixel.last_pixel) |=> !active_ff)
      else $error("line still active after its last pixel");

endmodule

`default_nettype wire

>>> design/line_pixel_generator.sv
// ---------------------------------------------------------------------------
// Line pixel generator
// Draws straight lines pixel by pixel with the Bresenham error rule.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat
//   req      in         req_valid / req_stall  start (two endpoints, color) or step
//   rsp      out        rsp_valid / rsp_stall  one pixel with its endpoint flag
//   csr      in         csr_write_enable       screen width or height
//
// An item passes an input register and a result register; one item per cycle
// is sustained while the result is not stalled. The stepping core updates
// the line state in the same cycle that loads the result register.
// Endpoints are clamped to the screen as they are captured.
// Reset is synchronous; it drops any line in progress and empties both stages.
// A stalled result holds its beat and any waiting item; req_stall rises only then.
`default_nettype none

module line_pixel_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire lpg_pkg::req_type                   req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      lpg_pkg::rsp_type                   rsp_data,
   input  wire logic                               csr_write_enable,
   input  wire logic [lpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lpg_pkg::CSR_BITS-1:0]       csr_data
);
   import lpg_pkg::*;

   // Largest legal coordinate for a given screen size.
   function automatic logic [COORD_BITS-1:0] coord_limit(input logic [CSR_BITS-1:0] size);
      logic [CSR_BITS-1:0] lim;
      lim = (size == '0) ? '0 : (size - 1'b1);
      if (32'(lim) > COORD_MAX) begin
         coord_limit = COORD_BITS'(COORD_MAX);
      end else begin
         coord_limit = COORD_BITS'(lim);
      end
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(input logic [COORD_BITS-1:0] c,
                                                   input logic [COORD_BITS-1:0] lim);
      clamp = (c > lim) ? lim : c;
   endfunction

   logic [COORD_BITS-1:0] x_lim_ff, x_lim_in;
   logic [COORD_BITS-1:0] y_lim_ff, y_lim_in;

   logic    stage_valid_ff, stage_valid_in;
   req_type stage_item_ff,  stage_item_in;
   logic    rsp_valid_ff,   rsp_valid_in;
   rsp_type rsp_data_ff,    rsp_data_in;

   logic     advance;
   logic     stage_load;
   logic     fire;
   step_type step;

   // Screen limits are kept already reduced to the last coordinate.
   always_comb begin
      x_lim_in = x_lim_ff;
      y_lim_in = y_lim_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  x_lim_in = coord_limit(csr_data);
            CSR_SCREEN_HEIGHT: y_lim_in = coord_limit(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_lim_ff <= coord_limit(SCREEN_WIDTH_RESET);
         y_lim_ff <= coord_limit(SCREEN_HEIGHT_RESET);
      end else begin
         x_lim_ff <= x_lim_in;
         y_lim_ff <= y_lim_in;
      end
   end

   // Pipeline flow: both stages move unless a result is held back.
   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign stage_load = !stage_valid_ff || advance;
   assign req_stall  = !stage_load;
   assign fire       = stage_valid_ff && advance;

   // Input register with endpoint clamping.
   always_comb begin
      stage_valid_in = stage_load ? req_valid : stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (stage_load) begin
         stage_item_in.kind       = req_data.kind;
         stage_item_in.start_x    = clamp(req_data.start_x, x_lim_ff);
         stage_item_in.start_y    = clamp(req_data.start_y, y_lim_ff);
         stage_item_in.end_x      = clamp(req_data.end_x, x_lim_ff);
         stage_item_in.end_y      = clamp(req_data.end_y, y_lim_ff);
         stage_item_in.line_color = req_data.line_color;
      end
   end

   lpg_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (stage_item_ff),
      .step  (step)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = advance ? (fire && step.emit) : rsp_valid_ff;
      rsp_data_in  = advance ? step.pixel : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The input side is held off only by a blocked result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && stage_valid_ff))
      else $error("input stalled without a blocked result");

   // A captured item that cannot move is kept.
   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_item_ff)))
      else $error("held item lost from the input register");

   // A stalled result beat stays valid and unchanged.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result beat changed");

endmodule

`default_nettype wire
